/* design/dmvm_pkg.sv */
// ----------------------------------------------------------------------------
// dmvm_pkg
// Shared constants and codes for the dense matrix-vector multiplier.
// ----------------------------------------------------------------------------
package dmvm_pkg;

    // Default store depth (vector length limit)
    localparam int MAX_COLUMNS_DEF = 1024;

    // Field widths
    localparam int ELEM_W    = 32;   // Q16.16 element
    localparam int VIDX_W    = 10;   // vector index
    localparam int SUM_W     = 64;   // Q32.32 accumulator
    localparam int ROW_W     = 16;   // row counter / row_count register
    localparam int CFG_COL_W = 11;   // column_count register

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 48;   // vector_index, element_value, pad
    localparam int M_TDATA_W = 80;   // row_sum, row_number

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;

    // Input item kind, carried in tuser
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MATRIX = 1'b1;

endpackage

/* design/dense_matrix_vector_multiply.sv */
// Result path: a request carrying a row's last matrix element passes the store
//   read, multiply and accumulate registers before m_axis_tvalid rises.
// Throughput: one request per cycle, vector loads and matrix elements alike,
//   unless back-pressured; set by the single MAC path and the one-read store port.
// Reset: counters, sum, flags and pipeline valids clear; column_count and
//   row_count return to 1. The vector store is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply
// Streams a row-major matrix against a stored vector and returns one saturated
// Q32.32 dot product per row, with row index, last-row mark and clip flag.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply #(
    parameter int MAX_COLUMNS = dmvm_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dmvm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmvm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] vector_index, [41:10] element_value, [47:42] zero
    input  logic [dmvm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] func
    input  logic                              s_axis_tuser,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [63:0] row_sum, [79:64] row_number
    output logic [dmvm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] saturated
    output logic                              m_axis_tuser,
    // final_row
    output logic                              m_axis_tlast
);

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CMP_W  = (ADDR_W + 1 > dmvm_pkg::CFG_COL_W) ?
                            ADDR_W + 1 : dmvm_pkg::CFG_COL_W;
    localparam logic [CMP_W-1:0] MAX_COLS_C = CMP_W'(MAX_COLUMNS);
    localparam int SW = dmvm_pkg::SUM_W;
    localparam int RW = dmvm_pkg::ROW_W;
    localparam int EW = dmvm_pkg::ELEM_W;

    // Configuration registers
    logic [dmvm_pkg::CFG_COL_W-1:0] r_cols;
    logic [RW-1:0]                  r_rows;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= dmvm_pkg::CFG_COL_W'(1);
            r_rows <= RW'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dmvm_pkg::CFG_COLUMN_COUNT: r_cols <= i_cfg_data[dmvm_pkg::CFG_COL_W-1:0];
                dmvm_pkg::CFG_ROW_COUNT:    r_rows <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Input fields
    logic [dmvm_pkg::VIDX_W-1:0] w_vidx;
    logic [EW-1:0]               w_elem;
    assign w_vidx = s_axis_tdata[dmvm_pkg::VIDX_W-1:0];
    assign w_elem = s_axis_tdata[dmvm_pkg::VIDX_W +: EW];

    // Pipeline flow control
    logic r_v0, r_v1, r_ovalid;
    logic r_last1;
    logic w_out_free, w_s1_ok, w_s1_free, w_s1_adv, w_s0_adv;
    logic w_in_acc, w_mat, w_load;

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_s1_ok       = !r_last1 || w_out_free;
    assign w_s1_adv      = r_v1 && w_s1_ok;
    assign w_s1_free     = !r_v1 || w_s1_ok;
    assign w_s0_adv      = r_v0 && w_s1_free;
    assign s_axis_tready = !r_v0 || w_s1_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_mat         = w_in_acc && (s_axis_tuser == dmvm_pkg::FUNC_MATRIX);
    assign w_load        = w_in_acc && (s_axis_tuser == dmvm_pkg::FUNC_LOAD);

    // Effective column and row limits
    logic [CMP_W-1:0] w_cols_eff;
    logic [RW-1:0]    w_rows_eff;
    logic [ADDR_W-1:0] r_col_pos;
    logic [RW-1:0]     r_row_pos;
    logic w_col_last, w_is_final, w_load_ok;

    always_comb begin
        if (r_cols == '0) begin
            w_cols_eff = CMP_W'(1);
        end else if (CMP_W'(r_cols) > MAX_COLS_C) begin
            w_cols_eff = MAX_COLS_C;
        end else begin
            w_cols_eff = CMP_W'(r_cols);
        end
        w_rows_eff = (r_rows == '0) ? RW'(1) : r_rows;
    end

    assign w_col_last = (CMP_W'(r_col_pos) + CMP_W'(1)) >= w_cols_eff;
    assign w_is_final = ({1'b0, r_row_pos} + (RW+1)'(1)) >= {1'b0, w_rows_eff};
    assign w_load_ok  = CMP_W'(w_vidx) < MAX_COLS_C;

    // Column and row position, advanced as matrix elements arrive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (w_mat) begin
            if (w_col_last) begin
                r_col_pos <= '0;
                r_row_pos <= w_is_final ? '0 : r_row_pos + RW'(1);
            end else begin
                r_col_pos <= r_col_pos + ADDR_W'(1);
            end
        end
    end

    // Vector store: write on load, registered read on matrix element
    logic [EW-1:0] r_vec_mem [MAX_COLUMNS];
    logic signed [EW-1:0] r_yv;
    logic signed [EW-1:0] r_elem0;
    logic          r_last0, r_final0;
    logic [RW-1:0] r_row0;

    always_ff @(posedge i_clk) begin
        if (w_load && w_load_ok) begin
            r_vec_mem[ADDR_W'(w_vidx)] <= w_elem;
        end
        if (w_mat) begin
            r_yv <= r_vec_mem[r_col_pos];
        end
    end

    // Stage 0 tags
    always_ff @(posedge i_clk) begin
        if (w_mat) begin
            r_elem0  <= w_elem;
            r_last0  <= w_col_last;
            r_final0 <= w_is_final;
            r_row0   <= r_row_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_mat) begin
            r_v0 <= 1'b1;
        end else if (w_s0_adv) begin
            r_v0 <= 1'b0;
        end
    end

    // Stage 1: exact Q32.32 product
    logic signed [SW-1:0] r_prod;
    logic          r_final1;
    logic [RW-1:0] r_row1;

    always_ff @(posedge i_clk) begin
        if (w_s0_adv) begin
            r_prod   <= r_elem0 * r_yv;
            r_last1  <= r_last0;
            r_final1 <= r_final0;
            r_row1   <= r_row0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_s0_adv) begin
            r_v1 <= 1'b1;
        end else if (w_s1_adv) begin
            r_v1 <= 1'b0;
        end
    end

    // Stage 2: saturating accumulate
    logic [SW-1:0] r_acc;
    logic          r_clip;
    logic [SW-1:0] w_sum;
    logic          w_ovf;
    logic [SW-1:0] n_acc;
    logic          n_clip;

    always_comb begin
        w_sum = r_acc + r_prod;
        w_ovf = (r_acc[SW-1] == r_prod[SW-1]) && (w_sum[SW-1] != r_acc[SW-1]);
        if (w_ovf) begin
            n_acc = r_acc[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            n_acc = w_sum;
        end
        n_clip = r_clip | w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (w_s1_adv) begin
            if (r_last1) begin
                r_acc  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_acc  <= n_acc;
                r_clip <= n_clip;
            end
        end
    end

    // Output register
    logic [SW-1:0] r_osum;
    logic [RW-1:0] r_orow;
    logic          r_ofinal, r_osat;

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_last1) begin
            r_osum   <= n_acc;
            r_orow   <= r_row1;
            r_ofinal <= r_final1;
            r_osat   <= n_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_s1_adv && r_last1) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_orow, r_osum};
    assign m_axis_tuser  = r_osat;
    assign m_axis_tlast  = r_ofinal;

    // Assertions
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && r_last1) |=> (r_acc == '0 && !r_clip))
        else $error("accumulator not cleared after row end");

    a_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && !w_s1_free) |=> ($stable(r_yv) && r_v0))
        else $error("stalled store read data changed");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mat && w_col_last && w_is_final) |=> (r_row_pos == '0 && r_col_pos == '0))
        else $error("row position did not wrap after final row");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |-> !(w_s1_adv && r_last1))
        else $error("result overwritten while stalled");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dense matrix-vector multiplier. Vector loads and
// matrix elements stream in through a queue-fed driver. A row-sum predictor
// tracks the vector store, counters and saturating accumulator, and a monitor
// checks every returned row against it, under several idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import dmvm_pkg::*;

    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STORE_DEPTH    = MAX_COLUMNS_DEF;
    localparam int RAND_PHASES    = 16;

    // Index with no register behind it; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;

    typedef struct packed {
        logic              func;
        logic [VIDX_W-1:0] vidx;
        logic [ELEM_W-1:0] value;
    } elem_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ROW_W-1:0] row;
        logic             last_row;
        logic             clipped;
    } row_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    dense_matrix_vector_multiply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Pending requests and predicted row results
    elem_req_t   pending_reqs[$];
    row_result_t row_results[$];
    elem_req_t   cur_req;
    row_result_t got_row;

    // Predictor state
    logic [ELEM_W-1:0]    vec_mem [0:STORE_DEPTH-1];
    logic [VIDX_W-1:0]    col_pos  = '0;
    logic [ROW_W-1:0]     row_pos  = '0;
    logic [SUM_W-1:0]     acc_sum  = '0;
    logic                 acc_clip = 1'b0;
    logic [CFG_COL_W-1:0] reg_cols = 11'd1;
    logic [ROW_W-1:0]     reg_rows = 16'd1;

    // Generator bookkeeping: store entries loaded so far
    bit loaded [0:STORE_DEPTH-1];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic int eff_cols(input logic [CFG_COL_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > STORE_DEPTH)
            return STORE_DEPTH;
        return int'(raw);
    endfunction

    // Model one accepted request: store write or multiply-accumulate
    task automatic apply_request(input elem_req_t r);
        logic [CFG_COL_W-1:0] cols;
        logic [ROW_W-1:0]     rows;
        logic [SUM_W-1:0]     prod;
        logic [SUM_W-1:0]     s;
        logic                 is_last;
        row_result_t          res;
        if (r.func == FUNC_LOAD) begin
            vec_mem[r.vidx] = r.value;
        end else begin
            cols = CFG_COL_W'(eff_cols(reg_cols));
            rows = (reg_rows == 0) ? 16'd1 : reg_rows;
            prod = longint'($signed(r.value)) * longint'($signed(vec_mem[col_pos]));
            s = acc_sum + prod;
            // Saturate when both addends share a sign that the sum lost
            if (acc_sum[63] == prod[63] && s[63] != acc_sum[63]) begin
                s = acc_sum[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                acc_clip = 1'b1;
            end
            acc_sum = s;
            if ((CFG_COL_W'(col_pos) + 11'd1) < cols) begin
                col_pos = col_pos + 1'b1;
            end else begin
                is_last = (row_pos >= rows - 16'd1);
                res.sum      = acc_sum;
                res.row      = row_pos;
                res.last_row = is_last;
                res.clipped  = acc_clip;
                row_results.push_back(res);
                col_pos  = '0;
                acc_sum  = '0;
                acc_clip = 1'b0;
                row_pos  = is_last ? 16'd0 : row_pos + 16'd1;
            end
        end
    endtask

    // Driver: one request slot, refilled from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                apply_request(cur_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, cur_req.value, cur_req.vidx};
                    s_axis_tuser  <= cur_req.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each returned row with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (row_results.size() == 0) begin
                report_mismatch("unexpected row", m_axis_tdata[63:0], '0);
            end else begin
                got_row = row_results.pop_front();
                if (m_axis_tdata[63:0] !== got_row.sum)
                    report_mismatch("row_sum", m_axis_tdata[63:0], got_row.sum);
                if (m_axis_tdata[79:64] !== got_row.row)
                    report_mismatch("row_number", 64'(m_axis_tdata[79:64]), 64'(got_row.row));
                if (m_axis_tlast !== got_row.last_row)
                    report_mismatch("final_row", 64'(m_axis_tlast), 64'(got_row.last_row));
                if (m_axis_tuser !== got_row.clipped)
                    report_mismatch("saturated", 64'(m_axis_tuser), 64'(got_row.clipped));
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Register write request; predictor config follows on acceptance
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_COLUMN_COUNT)
            reg_cols = data[CFG_COL_W-1:0];
        else if (idx == CFG_ROW_COUNT)
            reg_rows = data;
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until all requests are taken and all rows returned; sampled on the
    // falling edge so driver and monitor updates of this cycle have settled
    task automatic wait_quiet(input int extra);
        while (pending_reqs.size() != 0 || s_axis_tvalid || row_results.size() != 0)
            @(negedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(32'h0002_0000);
            5: return -$urandom_range(32'h0002_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(input int idx, input logic [ELEM_W-1:0] val);
        elem_req_t r;
        r.func  = FUNC_LOAD;
        r.vidx  = VIDX_W'(idx);
        r.value = val;
        loaded[idx] = 1'b1;
        pending_reqs.push_back(r);
    endtask

    task automatic push_elem(input logic [ELEM_W-1:0] val);
        elem_req_t r;
        r.func  = FUNC_MATRIX;
        r.vidx  = VIDX_W'($urandom);
        r.value = val;
        pending_reqs.push_back(r);
    endtask

    // Load every store entry that the coming rows may read
    task automatic ensure_loaded(input int n);
        for (int i = 0; i < n; i++)
            if (!loaded[i] || $urandom_range(3) == 0)
                push_load(i, rand_elem());
    endtask

    // Mostly matrix elements, with stray vector loads mixed in
    task automatic gen_traffic(input int n);
        repeat (n) begin
            if ($urandom_range(99) < 15)
                push_load($urandom_range(STORE_DEPTH - 1), rand_elem());
            else
                push_elem(rand_elem());
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] cols_data;
        logic [CFG_DATA_W-1:0] rows_data;
        int n;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: one column, one row, every result final
        push_load(0, 32'h7FFF_FFFF);
        push_elem(32'h7FFF_FFFF);
        push_elem(32'h8000_0000);
        push_load(STORE_DEPTH - 1, 32'h8000_0000);
        push_elem(32'h0000_0000);
        wait_quiet(LATENCY + 2);

        // Three columns of extremes: first row clips, load lands mid-row
        cfg_write(CFG_IDX_SPARE, 16'hFFFF);
        cfg_write(CFG_COLUMN_COUNT, 16'd3);
        cfg_write(CFG_ROW_COUNT, 16'd2);
        for (int i = 0; i < 3; i++)
            push_load(i, 32'h8000_0000);
        repeat (3) push_elem(32'h8000_0000);
        push_elem(32'h7FFF_FFFF);
        push_load(1, 32'h7FFF_FFFF);
        push_elem(32'h8000_0000);
        push_elem(32'h8000_0000);
        // Leave a row two elements in before shrinking the config
        push_elem(32'h8000_0000);
        push_elem(32'h8000_0000);
        wait_quiet(LATENCY + 2);

        // Column count zero and row count zero both act as one
        cfg_write(CFG_COLUMN_COUNT, 16'd0);
        cfg_write(CFG_ROW_COUNT, 16'd0);
        push_elem(32'h8000_0000);
        push_elem(32'h7FFF_FFFF);
        wait_quiet(LATENCY + 2);

        // Random phases, rotating through idling patterns
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if ($urandom_range(3) != 0) begin
                cols_data = CFG_DATA_W'($urandom);
                case ($urandom_range(5))
                    0: cols_data[CFG_COL_W-1:0] = 11'd0;
                    1: cols_data[CFG_COL_W-1:0] = 11'd1;
                    2: cols_data[CFG_COL_W-1:0] = 11'd2;
                    default: cols_data[CFG_COL_W-1:0] = CFG_COL_W'($urandom_range(3, 12));
                endcase
                cfg_write(CFG_COLUMN_COUNT, cols_data);
            end
            if ($urandom_range(3) != 0) begin
                case ($urandom_range(6))
                    0: rows_data = 16'd0;
                    1: rows_data = 16'd1;
                    2: rows_data = 16'hFFFF;
                    default: rows_data = CFG_DATA_W'($urandom_range(2, 6));
                endcase
                cfg_write(CFG_ROW_COUNT, rows_data);
            end
            n = $urandom_range(16, 40);
            ensure_loaded(eff_cols(reg_cols));
            gen_traffic(n / 2);
            // Sender holds off until every row so far has come back
            wait_quiet(0);
            gen_traffic(n - n / 2);
            wait_quiet(LATENCY + 2);
        end

        wait_quiet(LATENCY + 5);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
